>>> src/csf_pkg.sv
// Shared types, constants and register codes of the CSV field splitter.
// Used by every module of the block; depends on nothing else.
package csf_pkg;

    // Default line length in bytes; positions saturate at this value.
    localparam int LINE_BYTES_DEFAULT = 1024;

    // Width of the offset and length fields on the result channel.
    localparam int OUT_W = 11;

    // Width of the configuration index and data.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Backslash: an enclosure byte directly after it does not count.
    localparam logic [7:0] ESCAPE_BYTE = 8'h5C;

    // Register reset values.
    localparam logic [1:0] MODE_RESET       = 2'd2;
    localparam logic [7:0] FIELD_SEP_RESET  = 8'd44;
    localparam logic [7:0] LINE_SEP_RESET   = 8'd10;
    localparam logic [7:0] QUOTE_BYTE_RESET = 8'd34;

    // Enclosure modes. The unused code behaves as optional.
    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_REQUIRED = 2'd1,
        MODE_OPTIONAL = 2'd2
    } enclosure_mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENCLOSURE_MODE = 2'd0,
        CFG_FIELD_SEP      = 2'd1,
        CFG_LINE_SEP       = 2'd2,
        CFG_QUOTE_BYTE     = 2'd3
    } cfg_index_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] field_sep;
        logic [7:0] line_sep;
        logic [7:0] quote;
    } cfg_t;

    // One result beat.
    typedef struct packed {
        logic             valid;
        logic [OUT_W-1:0] offset;
        logic [OUT_W-1:0] length;
        logic             row_done;
    } result_t;

endpackage

>>> src/csf_config_regs.sv
// Configuration register file of the CSV field splitter.
// Depends on csf_pkg for the register codes, reset values and cfg_t.
module csf_config_regs
    import csf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index of a write beat.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ENCLOSURE_MODE: cfg_next.mode      = cfg_data[1:0];
                CFG_FIELD_SEP:      cfg_next.field_sep = cfg_data;
                CFG_LINE_SEP:       cfg_next.line_sep  = cfg_data;
                CFG_QUOTE_BYTE:     cfg_next.quote     = cfg_data;
                default:            cfg_next           = cfg_reg;
            endcase
        end
    end

    // Register storage with documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_RESET;
            cfg_reg.field_sep <= FIELD_SEP_RESET;
            cfg_reg.line_sep  <= LINE_SEP_RESET;
            cfg_reg.quote     <= QUOTE_BYTE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> src/csf_line_tracker.sv
// Per-line state and field decision logic of the CSV field splitter.
// Depends on csf_pkg; produces up to two result beats for each byte it consumes.
module csf_line_tracker
    import csf_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       fire,
    input  logic [7:0] text_byte,
    input  logic       last_of_line,
    output logic [1:0] result_count,
    output result_t    result0,
    output result_t    result1
);

    localparam int POS_W = $clog2(LINE_BYTES + 1);
    localparam logic [POS_W:0]   LINE_EXT = (POS_W + 1)'(LINE_BYTES);
    localparam logic [POS_W-1:0] LINE_MAX = POS_W'(LINE_BYTES);

    // Line state.
    logic [POS_W-1:0] byte_pos_reg,   byte_pos_next;
    logic [POS_W-1:0] start_pos_reg,  start_pos_next;
    logic [1:0]       quote_cnt_reg,  quote_cnt_next;
    logic [7:0]       prev_byte_reg,  prev_byte_next;
    logic [7:0]       first_byte_reg, first_byte_next;
    logic             any_field_reg,  any_field_next;

    // Saturate a widened position at the line length.
    function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W:0] v);
        logic [POS_W-1:0] r;
        r = (v > LINE_EXT) ? LINE_MAX : v[POS_W-1:0];
        return r;
    endfunction

    // Difference that stops at zero; never exceeds the line length here.
    function automatic logic [POS_W-1:0] diff_or_zero(input logic [POS_W:0] a,
                                                     input logic [POS_W:0] b);
        logic [POS_W:0] d;
        d = (a > b) ? (a - b) : '0;
        return d[POS_W-1:0];
    endfunction

    // Pack one valid field descriptor.
    function automatic result_t make_field(input logic [POS_W-1:0] off,
                                           input logic [POS_W-1:0] len);
        result_t r;
        r.valid    = 1'b1;
        r.offset   = OUT_W'(off);
        r.length   = OUT_W'(len);
        r.row_done = 1'b0;
        return r;
    endfunction

    logic [POS_W:0]   pos_ext;
    logic [POS_W:0]   start_ext;
    logic [POS_W-1:0] pos_plus1;
    logic             is_quote;
    logic [2:0]       quote_inc;
    logic [1:0]       quote_opt;
    logic [POS_W-1:0] start_q;
    logic [7:0]       first_q;
    logic [POS_W-1:0] trim_width;
    logic             trim_lead;
    logic             a_en;
    logic             b_en;
    result_t          res_a;
    result_t          res_b;
    result_t          res_fill;

    assign pos_ext   = {1'b0, byte_pos_reg};
    assign start_ext = {1'b0, start_pos_reg};
    assign pos_plus1 = sat_pos(pos_ext + 1'b1);
    assign is_quote  = (text_byte == cfg.quote) && (prev_byte_reg != ESCAPE_BYTE);
    assign quote_inc = {1'b0, quote_cnt_reg} + 3'd1;

    // Optional mode keeps the count within 0..3 with its parity.
    assign quote_opt = (quote_inc >= 3'd4) ? {1'b1, quote_inc[0]} : quote_inc[1:0];

    // Field decision for the current byte.
    always_comb
    begin
        start_pos_next  = start_pos_reg;
        quote_cnt_next  = quote_cnt_reg;
        first_byte_next = (byte_pos_reg == start_pos_reg) ? text_byte : first_byte_reg;
        any_field_next  = any_field_reg;
        start_q         = start_pos_reg;
        first_q         = first_byte_next;
        trim_width      = '0;
        trim_lead       = 1'b0;
        a_en            = 1'b0;
        b_en            = 1'b0;
        res_a           = '0;
        res_b           = '0;

        case (cfg.mode)
            MODE_NONE:
            begin
                if ((text_byte == cfg.field_sep) || (text_byte == cfg.line_sep))
                begin
                    a_en  = 1'b1;
                    res_a = make_field(start_pos_reg, diff_or_zero(pos_ext, start_ext));
                end
                if (text_byte == cfg.field_sep)
                begin
                    start_pos_next = pos_plus1;
                end
            end

            MODE_REQUIRED:
            begin
                // An opening enclosure marks the start; a closing one ends the field.
                if (is_quote)
                begin
                    if (quote_inc == 3'd1)
                    begin
                        start_pos_next  = byte_pos_reg;
                        first_byte_next = text_byte;
                        quote_cnt_next  = 2'd1;
                    end
                    else
                    begin
                        a_en  = 1'b1;
                        res_a = make_field(sat_pos(start_ext + 1'b1),
                                           diff_or_zero(pos_ext, start_ext + 1'b1));
                        any_field_next = 1'b1;
                        quote_cnt_next = 2'd0;
                    end
                end
                // At line end: a line with no pair is one field, an open field runs on.
                if (last_of_line)
                begin
                    if (!any_field_next)
                    begin
                        b_en  = 1'b1;
                        res_b = make_field('0, pos_plus1);
                    end
                    else if (quote_cnt_next == 2'd1)
                    begin
                        b_en  = 1'b1;
                        res_b = make_field(sat_pos({1'b0, start_pos_next} + 1'b1),
                                           diff_or_zero(pos_ext, {1'b0, start_pos_next}));
                    end
                end
            end

            default:
            begin
                // Optional mode: field separators split only at an even enclosure count.
                if (is_quote)
                begin
                    quote_cnt_next = quote_opt;
                    if (quote_opt == 2'd1)
                    begin
                        start_q = byte_pos_reg;
                        first_q = text_byte;
                    end
                end
                start_pos_next  = start_q;
                first_byte_next = first_q;

                // Trim one leading enclosure and, on wide fields, a trailing one.
                trim_width = diff_or_zero(pos_ext, {1'b0, start_q});
                trim_lead  = (first_q == cfg.quote);
                if ((trim_width > POS_W'(2)) && (prev_byte_reg == cfg.quote))
                begin
                    trim_width = trim_width - POS_W'(2);
                end

                if ((text_byte == cfg.field_sep) && !quote_cnt_next[0])
                begin
                    quote_cnt_next = 2'd0;
                    a_en           = 1'b1;
                    res_a = make_field(sat_pos({1'b0, start_q} + {{POS_W{1'b0}}, trim_lead}),
                                       trim_width);
                    start_pos_next = pos_plus1;
                end
                else if (text_byte == cfg.line_sep)
                begin
                    a_en  = 1'b1;
                    res_a = make_field(sat_pos({1'b0, start_q} + {{POS_W{1'b0}}, trim_lead}),
                                       trim_width);
                end
            end
        endcase
    end

    // Order the result beats and mark the last one of a line.
    always_comb
    begin
        res_fill = '0;
        result0  = a_en ? res_a : (b_en ? res_b : res_fill);
        result1  = res_b;
        if (a_en && b_en)
        begin
            result_count     = 2'd2;
            result1.row_done = last_of_line;
        end
        else if (a_en || b_en || last_of_line)
        begin
            result_count     = 2'd1;
            result0.row_done = last_of_line;
        end
        else
        begin
            result_count = 2'd0;
        end
    end

    // Advance the position, or clear the line after its last byte.
    always_comb
    begin
        if (last_of_line)
        begin
            byte_pos_next = '0;
            prev_byte_next = '0;
        end
        else
        begin
            byte_pos_next  = pos_plus1;
            prev_byte_next = text_byte;
        end
    end

    // State registers, updated when a byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= '0;
            start_pos_reg  <= '0;
            quote_cnt_reg  <= '0;
            prev_byte_reg  <= '0;
            first_byte_reg <= '0;
            any_field_reg  <= 1'b0;
        end
        else if (fire)
        begin
            byte_pos_reg  <= byte_pos_next;
            prev_byte_reg <= prev_byte_next;
            if (last_of_line)
            begin
                start_pos_reg  <= '0;
                quote_cnt_reg  <= '0;
                first_byte_reg <= '0;
                any_field_reg  <= 1'b0;
            end
            else
            begin
                start_pos_reg  <= start_pos_next;
                quote_cnt_reg  <= quote_cnt_next;
                first_byte_reg <= first_byte_next;
                any_field_reg  <= any_field_next;
            end
        end
    end

endmodule

>>> src/csf_result_queue.sv
// Two-entry result queue of the CSV field splitter; takes up to two beats at once.
// Depends on csf_pkg for result_t.
module csf_result_queue
    import csf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  result_t    push0,
    input  result_t    push1,
    output logic [1:0] room,
    output logic       head_valid,
    output result_t    head,
    input  logic       head_stall
);

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic [1:0] after_pop;

    assign head_valid = (count_reg != 2'd0);
    assign head       = slot0_reg;
    assign pop        = head_valid && !head_stall;
    assign after_pop  = count_reg - {1'b0, pop};
    assign room       = 2'd2 - after_pop;

    // Shift out the head beat, then append new beats behind what is left.
    always_comb
    begin
        case (after_pop)
            2'd0:
            begin
                slot0_next = push0;
                slot1_next = push1;
            end
            2'd1:
            begin
                slot0_next = pop ? slot1_reg : slot0_reg;
                slot1_next = push0;
            end
            default:
            begin
                slot0_next = slot0_reg;
                slot1_next = slot1_reg;
            end
        endcase
        count_next = after_pop + push_count;
    end

    // Beat storage needs no reset.
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // Fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

>>> src/csv_field_splitter_unit.sv
// Top level of the CSV field splitter: input register, line tracker, result queue.
// Depends on csf_pkg, csf_config_regs, csf_line_tracker and csf_result_queue.
//
// The splitter takes one byte of a text line per beat and returns field
// descriptors (offset, length) for the line under the enclosure mode set in
// its registers; the last beat of each line carries row_done, and a line
// with no field gives one beat with field_valid low. A byte is held in an
// input register and decided there by compare logic and small position
// counters, and its results are registered in the result queue. One byte is
// taken every cycle while the queue has room for all of that byte's beats. A
// byte can yield up to two result beats, so the two-entry result queue holds
// up a byte until its beats fit, and the rate is set by how fast the result
// side takes its beats. Configuration writes are always taken.
module csv_field_splitter_unit
    import csf_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   text_valid,
    output logic                   text_stall,
    input  logic [7:0]             text_byte,
    input  logic                   last_of_line,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic                   field_valid,
    output logic [OUT_W-1:0]       field_offset,
    output logic [OUT_W-1:0]       field_length,
    output logic                   row_done,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       fire;
    logic [1:0] result_count;
    logic [1:0] room;
    result_t    result0;
    result_t    result1;
    result_t    head;

    csf_config_regs u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held byte is consumed once all its result beats fit in the queue.
    assign fire       = in_valid_reg && (result_count <= room);
    assign text_stall = in_valid_reg && !fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!text_stall)
        begin
            in_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!text_stall)
        begin
            in_byte_reg <= text_byte;
            in_last_reg <= last_of_line;
        end
    end

    csf_line_tracker #(
        .LINE_BYTES (LINE_BYTES)
    ) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .fire         (fire),
        .text_byte    (in_byte_reg),
        .last_of_line (in_last_reg),
        .result_count (result_count),
        .result0      (result0),
        .result1      (result1)
    );

    csf_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (fire ? result_count : 2'd0),
        .push0      (result0),
        .push1      (result1),
        .room       (room),
        .head_valid (result_valid),
        .head       (head),
        .head_stall (result_stall)
    );

    // Result payload.
    assign field_valid  = head.valid;
    assign field_offset = head.offset;
    assign field_length = head.length;
    assign row_done     = head.row_done;

endmodule
